/* hdl/fcasl_pkg.sv */
package fcasl_pkg;

  localparam int NUM_CH      = 4;
  localparam int DATA_W      = 16;
  localparam int FRAC_BITS   = 14;
  localparam int TIME_W      = 32;
  localparam int RAMP_W      = 16;
  localparam int KIND_W      = 2;
  localparam int CFG_IDX_W   = 8;
  localparam int DT_CLAMP_MS = 100;
  localparam int IN_DATA_W   = TIME_W + NUM_CH * DATA_W;
  localparam int OUT_DATA_W  = NUM_CH * DATA_W;

  localparam logic [KIND_W-1:0] KIND_SET    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_RAMP_UP   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_DOWN = 8'd1;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } sl_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
  } sl_status_t;

endpackage

/* hdl/four_channel_asymmetric_slew_limiter.sv */
// Channel   Handshake                    Payload
// s_axis    s_axis_tvalid/s_axis_tready  tuser: kind; tdata: now_ms, 4 targets
// m_axis    m_axis_tvalid/m_axis_tready  tdata: 4 drive values
// cfg       cfg_valid_i/cfg_ready_o      cfg_index_i, cfg_data_i (ramp times)
//
// An update with both ramp times nonzero and nonzero elapsed time runs the
// restoring divider, which retires one quotient bit per cycle for both step
// limits in parallel. Other items skip the division steps. A new word is
// accepted while a result waits.
// A stalled output holds the next result in the commit step.
// Reset clears drives, targets and time base, ramp times return to 500 ms.
module four_channel_asymmetric_slew_limiter
  import fcasl_pkg::*;
#(
  parameter int DtClampMs = DT_CLAMP_MS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // now_ms[31:0], target_front_left, target_front_right, target_rear_left,
  // target_rear_right
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // kind
  input  logic [KIND_W-1:0]     s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // drive_front_left, drive_front_right, drive_rear_left, drive_rear_right
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [RAMP_W-1:0]     cfg_data_i
);

  sl_cmd_t    cmd;
  sl_status_t status;

  fcasl_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  fcasl_datapath #(
    .DtClampMs(DtClampMs)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (s_axis_tdata),
    .in_kind_i  (s_axis_tuser),
    .out_data_o (m_axis_tdata),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .status_o   (status)
  );

endmodule

/* hdl/fcasl_ctrl.sv */
module fcasl_ctrl
  import fcasl_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  input  sl_status_t status_i,
  output sl_cmd_t    cmd_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DIV    = 2'd1;
  localparam logic [1:0] ST_COMMIT = 2'd2;

  logic [1:0] state_q, state_d;
  logic       m_valid_q, m_valid_d;
  logic       out_free;

  assign out_free      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    m_valid_d   = m_valid_q && !m_axis_tready;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!status_i.need_div || status_i.div_done) begin
          state_d = ST_COMMIT;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      ST_COMMIT: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          m_valid_d    = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

`ifndef SYNTHESIS
  a_load_to_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == ST_DIV)
    else $error("load did not start division phase");
  a_commit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> m_valid_q)
    else $error("commit did not present a word");
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> (!m_valid_q || m_axis_tready))
    else $error("commit overwrote a pending word");
  a_skip_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && !status_i.need_div) |=> state_q == ST_COMMIT)
    else $error("division ran without need");
`endif

endmodule

/* hdl/fcasl_datapath.sv */
module fcasl_datapath
  import fcasl_pkg::*;
#(
  parameter int DtClampMs = DT_CLAMP_MS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [IN_DATA_W-1:0]  in_data_i,
  input  logic [KIND_W-1:0]     in_kind_i,
  output logic [OUT_DATA_W-1:0] out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [RAMP_W-1:0]     cfg_data_i,
  input  sl_cmd_t               cmd_i,
  output sl_status_t            status_o
);

  localparam int DtW   = $clog2(DtClampMs + 1);
  localparam int QW    = DtW + FRAC_BITS;
  localparam int CntW  = $clog2(QW + 1);
  localparam int LaneW = DATA_W + 2;
  localparam logic signed [LaneW-1:0] FullS = LaneW'(1 << FRAC_BITS);
  localparam logic [31:0] LimMax = 32'(2 << FRAC_BITS);

  logic [RAMP_W-1:0] ramp_up_q, ramp_down_q;
  logic signed [DATA_W-1:0] drive_q [NUM_CH];
  logic signed [DATA_W-1:0] goal_q  [NUM_CH];
  logic signed [DATA_W-1:0] tgt_q   [NUM_CH];
  logic signed [DATA_W-1:0] drive_next [NUM_CH];
  logic signed [DATA_W-1:0] slew_val   [NUM_CH];
  logic [TIME_W-1:0] last_q, now_q;
  logic [KIND_W-1:0] kind_q;
  logic              need_div_q, bypass;
  logic [TIME_W-1:0] dt_full;
  logic [DtW-1:0]    dt_clamped;
  logic [QW-1:0]     dq_q [2];
  logic [QW-1:0]     dq_d [2];
  logic [RAMP_W-1:0] rem_q [2];
  logic [RAMP_W-1:0] rem_d [2];
  logic [RAMP_W-1:0] divisor [2];
  logic [CntW-1:0]   cnt_q;
  logic [LaneW-1:0]  lim [2];
  logic signed [DATA_W-1:0] out_q [NUM_CH];

  function automatic logic signed [DATA_W-1:0] clamp_full(logic signed [DATA_W-1:0] v);
    logic signed [LaneW-1:0] w;
    w = LaneW'(v);
    if (w > FullS) begin
      return DATA_W'(FullS);
    end else if (w < -FullS) begin
      return DATA_W'(-FullS);
    end
    return v;
  endfunction

  assign cfg_ready_o = 1'b1;
  assign bypass      = (ramp_up_q == '0) || (ramp_down_q == '0);
  assign dt_full     = in_data_i[TIME_W-1:0] - last_q;
  assign dt_clamped  = (dt_full > TIME_W'(DtClampMs)) ? DtW'(DtClampMs) : dt_full[DtW-1:0];
  assign divisor[0]  = ramp_up_q;
  assign divisor[1]  = ramp_down_q;

  assign status_o.need_div = need_div_q;
  assign status_o.div_done = (cnt_q == CntW'(QW));

  always_comb begin
    logic [RAMP_W:0]   shifted;
    logic [RAMP_W+1:0] diff;
    for (int k = 0; k < 2; k++) begin
      shifted  = {rem_q[k], dq_q[k][QW-1]};
      diff     = {1'b0, shifted} - {2'b00, divisor[k]};
      if (!diff[RAMP_W+1]) begin
        rem_d[k] = diff[RAMP_W-1:0];
        dq_d[k]  = {dq_q[k][QW-2:0], 1'b1};
      end else begin
        rem_d[k] = shifted[RAMP_W-1:0];
        dq_d[k]  = {dq_q[k][QW-2:0], 1'b0};
      end
      lim[k] = (32'(dq_q[k]) > LimMax) ? LaneW'(LimMax) : LaneW'(dq_q[k]);
    end
  end

  always_comb begin
    logic signed [LaneW-1:0] cur, goal, delta, sum, l;
    logic [LaneW-1:0]        mag_c, mag_g;
    for (int i = 0; i < NUM_CH; i++) begin
      cur   = LaneW'(drive_q[i]);
      goal  = LaneW'(goal_q[i]);
      mag_c = (cur < 0) ? LaneW'(-cur) : LaneW'(cur);
      mag_g = (goal < 0) ? LaneW'(-goal) : LaneW'(goal);
      l     = signed'((mag_g < mag_c) ? lim[1] : lim[0]);
      delta = goal - cur;
      if (delta > l) begin
        delta = l;
      end else if (delta < -l) begin
        delta = -l;
      end
      sum = cur + delta;
      if (sum > FullS) begin
        sum = FullS;
      end else if (sum < -FullS) begin
        sum = -FullS;
      end
      slew_val[i] = sum[DATA_W-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      drive_next[i] = drive_q[i];
      case (kind_q)
        KIND_UPDATE: begin
          if (bypass) begin
            drive_next[i] = goal_q[i];
          end else if (need_div_q) begin
            drive_next[i] = slew_val[i];
          end
        end
        KIND_CLEAR: begin
          drive_next[i] = '0;
        end
        default: begin
          drive_next[i] = drive_q[i];
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_up_q   <= RAMP_W'(500);
      ramp_down_q <= RAMP_W'(500);
      last_q      <= '0;
      need_div_q  <= 1'b0;
      cnt_q       <= '0;
      for (int i = 0; i < NUM_CH; i++) begin
        drive_q[i] <= '0;
        goal_q[i]  <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_RAMP_UP:   ramp_up_q   <= cfg_data_i;
          REG_RAMP_DOWN: ramp_down_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (cmd_i.load) begin
        need_div_q <= (in_kind_i == KIND_UPDATE) && !bypass && (dt_full != '0);
        cnt_q      <= '0;
      end else if (cmd_i.step) begin
        cnt_q <= cnt_q + CntW'(1);
      end
      if (cmd_i.commit) begin
        for (int i = 0; i < NUM_CH; i++) begin
          drive_q[i] <= drive_next[i];
        end
        case (kind_q)
          KIND_SET: begin
            for (int i = 0; i < NUM_CH; i++) begin
              goal_q[i] <= tgt_q[i];
            end
          end
          KIND_UPDATE: begin
            if (bypass || need_div_q) begin
              last_q <= now_q;
            end
          end
          KIND_CLEAR: begin
            last_q <= now_q;
            for (int i = 0; i < NUM_CH; i++) begin
              goal_q[i] <= '0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= in_kind_i;
      now_q  <= in_data_i[TIME_W-1:0];
      for (int i = 0; i < NUM_CH; i++) begin
        tgt_q[i] <= clamp_full(in_data_i[TIME_W + i*DATA_W +: DATA_W]);
      end
      for (int k = 0; k < 2; k++) begin
        dq_q[k]  <= QW'(dt_clamped) << FRAC_BITS;
        rem_q[k] <= '0;
      end
    end else if (cmd_i.step) begin
      for (int k = 0; k < 2; k++) begin
        dq_q[k]  <= dq_d[k];
        rem_q[k] <= rem_d[k];
      end
    end
    if (cmd_i.commit) begin
      for (int i = 0; i < NUM_CH; i++) begin
        out_q[i] <= drive_next[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      out_data_o[i*DATA_W +: DATA_W] = out_q[i];
    end
  end

`ifndef SYNTHESIS
  a_step_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (ramp_up_q != '0 && ramp_down_q != '0))
    else $error("divider stepped with zero ramp time");
  a_drive_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> (LaneW'(drive_q[0]) <= FullS && LaneW'(drive_q[0]) >= -FullS
                   && LaneW'(drive_q[3]) <= FullS && LaneW'(drive_q[3]) >= -FullS))
    else $error("drive value out of range");
  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> cnt_q < CntW'(QW))
    else $error("divider stepped past quotient width");
`endif

endmodule

/* tb/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import fcasl_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam longint FULL = longint'(1) << FRAC_BITS;
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOP = 8'hFF;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata;
  logic [KIND_W-1:0] s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [RAMP_W-1:0] cfg_data_i;

  logic [RAMP_W-1:0] ramp_up_ms_q;
  logic [RAMP_W-1:0] ramp_down_ms_q;
  longint drive_q[NUM_CH];
  longint goal_q[NUM_CH];
  logic [TIME_W-1:0] stamp_q;
  logic [OUT_DATA_W-1:0] pending_drives[$];

  int err_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  logic [TIME_W-1:0] clock_ms = '0;
  string ch_name[NUM_CH] = '{"drive_front_left", "drive_front_right",
                             "drive_rear_left", "drive_rear_right"};

  four_channel_asymmetric_slew_limiter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic longint sat_full(longint v);
    if (v > FULL) return FULL;
    if (v < -FULL) return -FULL;
    return v;
  endfunction

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic [OUT_DATA_W-1:0] apply_item(logic [KIND_W-1:0] kind,
      logic [TIME_W-1:0] now, logic [NUM_CH*DATA_W-1:0] tgt);
    logic [TIME_W-1:0] dt;
    longint up;
    longint dn;
    longint lim;
    longint delta;
    logic [OUT_DATA_W-1:0] word;
    case (kind)
      KIND_SET: begin
        for (int ch = 0; ch < NUM_CH; ch++)
          goal_q[ch] = sat_full(longint'($signed(tgt[ch*DATA_W +: DATA_W])));
      end
      KIND_UPDATE: begin
        if (ramp_up_ms_q == 0 || ramp_down_ms_q == 0) begin
          for (int ch = 0; ch < NUM_CH; ch++) drive_q[ch] = goal_q[ch];
          stamp_q = now;
        end else begin
          dt = now - stamp_q;
          if (dt != 0) begin
            if (dt > DT_CLAMP_MS) dt = DT_CLAMP_MS;
            stamp_q = now;
            up = (longint'(dt) * FULL) / longint'(ramp_up_ms_q);
            dn = (longint'(dt) * FULL) / longint'(ramp_down_ms_q);
            for (int ch = 0; ch < NUM_CH; ch++) begin
              delta = goal_q[ch] - drive_q[ch];
              lim = (mag(goal_q[ch]) < mag(drive_q[ch])) ? dn : up;
              if (delta > lim) delta = lim;
              else if (delta < -lim) delta = -lim;
              drive_q[ch] = sat_full(drive_q[ch] + delta);
            end
          end
        end
      end
      KIND_CLEAR: begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
          drive_q[ch] = 0;
          goal_q[ch] = 0;
        end
        stamp_q = now;
      end
      default: ;
    endcase
    for (int ch = 0; ch < NUM_CH; ch++) word[ch*DATA_W +: DATA_W] = drive_q[ch][DATA_W-1:0];
    return word;
  endfunction

  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_drives
    logic [OUT_DATA_W-1:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_drives.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, m_axis_tdata);
        err_count++;
      end else begin
        want = pending_drives.pop_front();
        for (int ch = 0; ch < NUM_CH; ch++) begin
          if (want[ch*DATA_W +: DATA_W] !== m_axis_tdata[ch*DATA_W +: DATA_W]) begin
            $display("%0t: %s expected %0d actual %0d", $time, ch_name[ch],
                     $signed(want[ch*DATA_W +: DATA_W]),
                     $signed(m_axis_tdata[ch*DATA_W +: DATA_W]));
            err_count++;
          end
        end
      end
    end
  end

  function automatic logic [DATA_W-1:0] rand_target();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return DATA_W'(int'($urandom_range(32768)) - 16384);
    if (r < 75) begin
      case ($urandom_range(3))
        0: return DATA_W'(FULL);
        1: return DATA_W'(-FULL);
        2: return 16'h7FFF;
        default: return 16'h8000;
      endcase
    end
    return DATA_W'($urandom);
  endfunction

  function automatic logic [RAMP_W-1:0] pick_ramp();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 10) return RAMP_W'($urandom_range(1, 10));
    if (r < 85) return RAMP_W'($urandom_range(20, 2000));
    return RAMP_W'($urandom_range(2000, 65535));
  endfunction

  task automatic send_word(logic [KIND_W-1:0] kind, logic [TIME_W-1:0] now,
                           logic [DATA_W-1:0] fl, fr, rl, rr);
    logic [NUM_CH*DATA_W-1:0] tgt;
    tgt = {rr, rl, fr, fl};
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {tgt, now};
    s_axis_tuser <= kind;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_drives.push_back(apply_item(kind, now, tgt));
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending_drives.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [RAMP_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == REG_RAMP_UP) ramp_up_ms_q = val;
    else if (idx == REG_RAMP_DOWN) ramp_down_ms_q = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_update(logic [TIME_W-1:0] now);
    send_word(KIND_UPDATE, now, rand_target(), rand_target(), rand_target(), rand_target());
  endtask

  task automatic send_random_set();
    send_word(KIND_SET, $urandom, rand_target(), rand_target(), rand_target(), rand_target());
  endtask

  task automatic random_word();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 20) begin
      send_random_set();
    end else if (r < 85) begin
      clock_ms += $urandom_range(0, 120);
      send_update(clock_ms);
    end else if (r < 89) begin
      clock_ms = $urandom;
      send_update(clock_ms);
    end else if (r < 94) begin
      clock_ms += $urandom_range(0, 50);
      send_word(KIND_CLEAR, clock_ms, rand_target(), rand_target(), rand_target(),
                rand_target());
    end else begin
      send_word(KIND_SPARE, $urandom, rand_target(), rand_target(), rand_target(),
                rand_target());
    end
  endtask

  task automatic test_reset_defaults();
    send_word(KIND_SET, 32'hFFFF_FFFF, DATA_W'(FULL), DATA_W'(FULL), DATA_W'(-FULL),
              DATA_W'(-FULL));
    send_update(32'd100);
    send_update(32'd150);
    send_word(KIND_SPARE, $urandom, rand_target(), rand_target(), rand_target(),
              rand_target());
  endtask

  task automatic test_target_extremes();
    send_word(KIND_SET, 32'd0, 16'h8000, 16'h7FFF, 16'd16385, 16'(-16385));
    send_update(32'd250);
    send_word(KIND_SET, 32'hA5A5_5A5A, 16'd0, 16'hFFFF, 16'd1, DATA_W'(FULL));
    send_update(32'd1250);
  endtask

  task automatic test_time_edges();
    send_update(32'd1250);
    send_update(32'd1251);
    send_word(KIND_CLEAR, 32'hFFFF_FFF0, rand_target(), rand_target(), rand_target(),
              rand_target());
    send_word(KIND_SET, 32'd0, DATA_W'(FULL), DATA_W'(-FULL), 16'd8000, 16'(-8000));
    send_update(32'h0000_0010);
    send_update(32'h8000_0000);
    clock_ms = 32'h8000_0000;
  endtask

  task automatic test_ramp_settings();
    wait_idle();
    write_reg(REG_RAMP_UP, '0);
    send_random_set();
    send_update($urandom);
    wait_idle();
    write_reg(REG_RAMP_UP, 16'd1);
    write_reg(REG_RAMP_DOWN, 16'hFFFF);
    send_word(KIND_SET, 32'd0, 16'd0, DATA_W'(FULL), DATA_W'(-FULL), 16'd100);
    clock_ms += 100;
    send_update(clock_ms);
    wait_idle();
    write_reg(REG_RAMP_UP, 16'hFFFF);
    write_reg(REG_RAMP_DOWN, 16'd1);
    write_reg(REG_SPARE, 16'hFFFF);
    write_reg(REG_TOP, 16'hFFFF);
    send_word(KIND_SET, 32'd0, DATA_W'(FULL), 16'd0, DATA_W'(FULL), DATA_W'(-FULL));
    clock_ms += 100;
    send_update(clock_ms);
    wait_idle();
    write_reg(REG_RAMP_DOWN, '0);
    send_update(clock_ms);
    wait_idle();
    write_reg(REG_RAMP_UP, 16'd500);
    write_reg(REG_RAMP_DOWN, 16'd500);
  endtask

  task automatic test_clear();
    send_random_set();
    clock_ms += 60;
    send_update(clock_ms);
    clock_ms = $urandom;
    send_word(KIND_CLEAR, clock_ms, rand_target(), rand_target(), rand_target(),
              rand_target());
    clock_ms += 50;
    send_update(clock_ms);
  endtask

  task automatic test_backpressure();
    wait_idle();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 400;
    repeat (40) random_word();
    wait_idle();
  endtask

  task automatic test_random_phase(int send_pct, int recv_pct, int count);
    wait_idle();
    write_reg(REG_RAMP_UP, pick_ramp());
    write_reg(REG_RAMP_DOWN, pick_ramp());
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    repeat (count) random_word();
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    ramp_up_ms_q = 16'd500;
    ramp_down_ms_q = 16'd500;
    stamp_q = '0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      drive_q[ch] = 0;
      goal_q[ch] = 0;
    end
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_target_extremes();
    test_time_edges();
    test_ramp_settings();
    test_clear();
    test_backpressure();
    test_random_phase(0, 0, 105);
    test_random_phase(65, 0, 105);
    test_random_phase(0, 65, 105);
    test_random_phase(24, 24, 105);

    wait_idle();
    repeat (60) @(posedge clk_i);
    if (err_count == 0 && pending_drives.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
